### sv/rx_frame_address_and_duplicate_filter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rx frame filter
// Implication checks sampled on clk, muted while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RX_FRAME_ADDRESS_AND_DUPLICATE_FILTER_ASSERT_SVH
`define RX_FRAME_ADDRESS_AND_DUPLICATE_FILTER_ASSERT_SVH

// same-cycle implication
`define RXAFDF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rxafdf: same-cycle check failed");

// next-cycle implication
`define RXAFDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rxafdf: next-cycle check failed");

`endif

### sv/rxafdf_pkg.sv
// ----------------------------------------------------------------------------
// rxafdf_pkg
// Types and codes shared by the rx frame address and duplicate filter.
// ----------------------------------------------------------------------------
package rxafdf_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPRESSED_MODE = 2'd1;
    localparam logic [15:0]            OWN_ADDRESS_RESET   = 16'd1;

    // stream payload widths (bytes rounded)
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 48;

    // one table entry: source in the low half, last sequence in the high half
    localparam int ENTRY_W = 32;

    typedef enum logic [1:0] {
        VERDICT_DELIVERED  = 2'd0,
        VERDICT_WRONG_ADDR = 2'd1,
        VERDICT_DUPLICATE  = 2'd2,
        VERDICT_RADIO      = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILTER,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [15:0] dest_address;
        logic [15:0] source_address;
        logic [15:0] frame_sequence;
        logic        ack_requested;
        logic [3:0]  overlapping_signals;
        logic        radio_powered_down;
        logic [4:0]  next_channel_hint;
    } item_t;

    typedef struct packed {
        verdict_t    verdict;
        logic        send_ack;
        logic [15:0] ack_target;
        logic [15:0] ack_sequence;
        logic [4:0]  ack_channel;
        logic        table_full;
    } result_t;

endpackage

### sv/rxafdf_ram.sv
// ----------------------------------------------------------------------------
// rxafdf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rxafdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/rx_frame_address_and_duplicate_filter.sv
// ----------------------------------------------------------------------------
// rx_frame_address_and_duplicate_filter
// Address, radio and duplicate filter for received data frames.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A frame dropped for its address or, in
// compressed mode, for a busy or powered-down radio goes from IDLE through
// FILTER to EMIT; a frame that reaches the neighbor table also passes
// through SEARCH, which scans entries until a match or the last used entry,
// and SEARCH is skipped when the table is still empty.
// The scan reads the neighbor RAM one entry per cycle, so TABLE_ENTRIES sets
// the worst case. Entries fill in order and a fill
// count marks which are valid, so there is no clearing pass after reset. A
// finished result sits in an output register and the next frame is taken
// while it waits; a result that finds that register still full holds the
// block until the receiver takes the waiting beat.
// ----------------------------------------------------------------------------
module rx_frame_address_and_duplicate_filter #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [rxafdf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rxafdf_pkg::CFG_DATA_W-1:0]    cfg_data,
    // frame in
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // dest_address[15:0], source_address[31:16], frame_sequence[47:32],
    // ack_requested[48], overlapping_signals[52:49], radio_powered_down[53],
    // next_channel_hint[58:54], zero pad[63:59]
    input  logic [rxafdf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // verdict out
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // verdict[1:0], send_ack[2], ack_target[18:3], ack_sequence[34:19],
    // ack_channel[39:35], table_full[40], zero pad[47:41]
    output logic [rxafdf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

`include "rx_frame_address_and_duplicate_filter_assert.svh"

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] ENTRIES_MAX = CW'(TABLE_ENTRIES);
    localparam logic [CW-1:0] ONE_COUNT   = CW'(1);

    // configuration registers
    logic [15:0] own_address_reg;
    logic        compressed_mode_reg;

    // control
    rxafdf_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       used_reg, used_next;

    // payload
    rxafdf_pkg::item_t   item_reg, item_next;
    rxafdf_pkg::result_t res_reg, res_next;
    rxafdf_pkg::result_t out_data_reg, out_data_next;
    logic                out_valid_reg, out_valid_next;

    // RAM ports
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [rxafdf_pkg::ENTRY_W-1:0] ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [rxafdf_pkg::ENTRY_W-1:0] ram_rdata;

    // decode helpers
    logic        wrong_addr;
    logic        radio_busy;
    logic        drop;
    logic        entry_match;
    logic        entry_newer;
    logic        at_last;
    logic        room;
    logic        out_free;
    logic [15:0] rd_source;
    logic [15:0] rd_sequence;

    rxafdf_ram #(
        .WIDTH (rxafdf_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // input unpack
    always_comb
    begin
        item_next                     = item_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_next.dest_address        = s_axis_tdata[15:0];
            item_next.source_address      = s_axis_tdata[31:16];
            item_next.frame_sequence      = s_axis_tdata[47:32];
            item_next.ack_requested       = s_axis_tdata[48];
            item_next.overlapping_signals = s_axis_tdata[52:49];
            item_next.radio_powered_down  = s_axis_tdata[53];
            item_next.next_channel_hint   = s_axis_tdata[58:54];
        end
    end

    // frame checks and table compare
    assign wrong_addr  = (item_reg.dest_address != 16'd0) &&
                         (item_reg.dest_address != own_address_reg);
    assign radio_busy  = compressed_mode_reg &&
                         ((item_reg.overlapping_signals > 4'd1) ||
                          item_reg.radio_powered_down);
    assign drop        = wrong_addr || radio_busy;
    assign rd_source   = ram_rdata[15:0];
    assign rd_sequence = ram_rdata[31:16];
    assign entry_match = (rd_source == item_reg.source_address);
    assign entry_newer = (rd_sequence < item_reg.frame_sequence);
    assign at_last     = ((CW'(idx_reg) + ONE_COUNT) == used_reg);
    assign room        = (used_reg < ENTRIES_MAX);
    assign out_free    = !out_valid_reg || m_axis_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rxafdf_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = rxafdf_pkg::ST_FILTER;
                end
            end
            rxafdf_pkg::ST_FILTER:
            begin
                if (drop || (used_reg == '0))
                begin
                    state_next = rxafdf_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = rxafdf_pkg::ST_SEARCH;
                end
            end
            rxafdf_pkg::ST_SEARCH:
            begin
                if (entry_match || at_last)
                begin
                    state_next = rxafdf_pkg::ST_EMIT;
                end
            end
            rxafdf_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = rxafdf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rxafdf_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        s_axis_tready  = 1'b0;
        idx_next       = idx_reg;
        used_next      = used_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        ram_we         = 1'b0;
        ram_waddr      = used_reg[AW-1:0];
        ram_wdata      = {item_reg.frame_sequence, item_reg.source_address};
        ram_re         = 1'b0;
        ram_raddr      = idx_reg + AW'(1);

        unique case (state_reg)
            rxafdf_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            rxafdf_pkg::ST_FILTER:
            begin
                res_next.verdict      = rxafdf_pkg::VERDICT_DELIVERED;
                res_next.send_ack     = 1'b0;
                res_next.ack_target   = 16'd0;
                res_next.ack_sequence = 16'd0;
                res_next.ack_channel  = 5'd0;
                res_next.table_full   = 1'b0;
                if (wrong_addr)
                begin
                    res_next.verdict = rxafdf_pkg::VERDICT_WRONG_ADDR;
                end
                else if (radio_busy)
                begin
                    res_next.verdict = rxafdf_pkg::VERDICT_RADIO;
                end
                else
                begin
                    if (item_reg.ack_requested)
                    begin
                        res_next.send_ack     = 1'b1;
                        res_next.ack_target   = item_reg.source_address;
                        res_next.ack_sequence = item_reg.frame_sequence;
                        res_next.ack_channel  = compressed_mode_reg ?
                                                item_reg.next_channel_hint : 5'd0;
                    end
                    if (used_reg == '0)
                    begin
                        // empty table: record the source at once
                        ram_we    = 1'b1;
                        used_next = used_reg + ONE_COUNT;
                    end
                    else
                    begin
                        // start the scan at entry 0
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        idx_next  = '0;
                    end
                end
            end
            rxafdf_pkg::ST_SEARCH:
            begin
                if (entry_match)
                begin
                    if (entry_newer)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = idx_reg;
                    end
                    else
                    begin
                        res_next.verdict = rxafdf_pkg::VERDICT_DUPLICATE;
                    end
                end
                else if (at_last)
                begin
                    // unknown source: append or flag a full table
                    if (room)
                    begin
                        ram_we    = 1'b1;
                        used_next = used_reg + ONE_COUNT;
                    end
                    else
                    begin
                        res_next.table_full = 1'b1;
                    end
                end
                else
                begin
                    // prefetch the next entry
                    ram_re   = 1'b1;
                    idx_next = idx_reg + AW'(1);
                end
            end
            rxafdf_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= rxafdf_pkg::ST_IDLE;
            idx_reg             <= '0;
            used_reg            <= '0;
            out_valid_reg       <= 1'b0;
            own_address_reg     <= rxafdf_pkg::OWN_ADDRESS_RESET;
            compressed_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                priority if (cfg_index == rxafdf_pkg::CFG_OWN_ADDRESS)
                begin
                    own_address_reg <= cfg_data[15:0];
                end
                else if (cfg_index == rxafdf_pkg::CFG_COMPRESSED_MODE)
                begin
                    compressed_mode_reg <= cfg_data[0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // output pack
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            out_data_reg.table_full,
                            out_data_reg.ack_channel,
                            out_data_reg.ack_sequence,
                            out_data_reg.ack_target,
                            out_data_reg.send_ack,
                            out_data_reg.verdict};

    // checks
    `RXAFDF_ASSERT_SAME(a_used_bound, 1'b1, used_reg <= ENTRIES_MAX)
    `RXAFDF_ASSERT_SAME(a_scan_in_range, state_reg == rxafdf_pkg::ST_SEARCH,
        (CW'(idx_reg) < used_reg))
    `RXAFDF_ASSERT_NEXT(a_used_grows_on_write, used_next != used_reg,
        ($past(ram_we) && (used_reg == $past(used_reg) + ONE_COUNT)))

endmodule

### dv/rxafdf_verdict_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rxafdf_verdict_checker
// Watches the config port and both stream channels of the rx frame filter.
// Keeps its own copy of the settings and the neighbor table, predicts the
// verdict beat of every accepted frame and compares it, field by field,
// with the verdict beats that leave the block.
// ----------------------------------------------------------------------------
module rxafdf_verdict_checker #(
    parameter int NEIGHBORS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rxafdf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rxafdf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [rxafdf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [rxafdf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output int                                   mismatches,
    output int                                   verdicts_pending
);
    import rxafdf_pkg::*;

    // shadow settings and neighbor table
    logic [15:0] own_addr;
    logic        compressed;
    logic        nb_valid    [NEIGHBORS];
    logic [15:0] nb_source   [NEIGHBORS];
    logic [15:0] nb_last_seq [NEIGHBORS];
    int          nb_used;
    int          fail_count;
    result_t     expected_verdicts [$];

    // verdict of one frame; updates the shadow table like the block does
    function automatic result_t filter_frame(input item_t f);
        result_t r;
        logic    hit;
        int      k;
        r = '0;
        r.verdict = VERDICT_DELIVERED;
        hit = 1'b0;
        if (f.dest_address != 16'd0 && f.dest_address != own_addr)
            r.verdict = VERDICT_WRONG_ADDR;
        else if (compressed && (f.overlapping_signals > 4'd1 || f.radio_powered_down))
            r.verdict = VERDICT_RADIO;
        else
        begin
            // ACK decision comes ahead of the duplicate check
            if (f.ack_requested)
            begin
                r.send_ack     = 1'b1;
                r.ack_target   = f.source_address;
                r.ack_sequence = f.frame_sequence;
                r.ack_channel  = compressed ? f.next_channel_hint : 5'd0;
            end
            for (k = 0; k < NEIGHBORS; k++)
            begin
                if (!hit && nb_valid[k] && nb_source[k] == f.source_address)
                begin
                    hit = 1'b1;
                    if (nb_last_seq[k] < f.frame_sequence)
                        nb_last_seq[k] = f.frame_sequence;
                    else
                        r.verdict = VERDICT_DUPLICATE;
                end
            end
            // unknown source: record it, or flag a full table
            if (!hit)
            begin
                if (nb_used < NEIGHBORS)
                begin
                    nb_valid[nb_used]    = 1'b1;
                    nb_source[nb_used]   = f.source_address;
                    nb_last_seq[nb_used] = f.frame_sequence;
                    nb_used++;
                end
                else
                    r.table_full = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        item_t   f;
        result_t got;
        result_t want;
        int      k;
        if (!rst_n)
        begin
            own_addr   = OWN_ADDRESS_RESET;
            compressed = 1'b0;
            for (k = 0; k < NEIGHBORS; k++)
                nb_valid[k] = 1'b0;
            nb_used    = 0;
            fail_count = 0;
            expected_verdicts.delete();
            mismatches       <= 0;
            verdicts_pending <= 0;
        end
        else
        begin
            // verdict beat out
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.verdict      = verdict_t'(m_axis_tdata[1:0]);
                got.send_ack     = m_axis_tdata[2];
                got.ack_target   = m_axis_tdata[18:3];
                got.ack_sequence = m_axis_tdata[34:19];
                got.ack_channel  = m_axis_tdata[39:35];
                got.table_full   = m_axis_tdata[40];
                if (expected_verdicts.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: verdict beat with none expected: verdict=%0d ack=%0b",
                                 $realtime, got.verdict, got.send_ack);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got.verdict !== want.verdict || got.send_ack !== want.send_ack ||
                        got.ack_target !== want.ack_target ||
                        got.ack_sequence !== want.ack_sequence ||
                        got.ack_channel !== want.ack_channel ||
                        got.table_full !== want.table_full)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: verdict mismatch", $realtime);
                            $display("  exp verdict=%0d ack=%0b target=%h seq=%h chan=%0d full=%0b",
                                     want.verdict, want.send_ack, want.ack_target,
                                     want.ack_sequence, want.ack_channel, want.table_full);
                            $display("  got verdict=%0d ack=%0b target=%h seq=%h chan=%0d full=%0b",
                                     got.verdict, got.send_ack, got.ack_target,
                                     got.ack_sequence, got.ack_channel, got.table_full);
                        end
                    end
                end
            end

            // register writes; other indexes are ignored
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OWN_ADDRESS:     own_addr   = cfg_data[15:0];
                    CFG_COMPRESSED_MODE: compressed = cfg_data[0];
                    default:             ;
                endcase
            end

            // frame beat in
            if (s_axis_tvalid && s_axis_tready)
            begin
                f.dest_address        = s_axis_tdata[15:0];
                f.source_address      = s_axis_tdata[31:16];
                f.frame_sequence      = s_axis_tdata[47:32];
                f.ack_requested       = s_axis_tdata[48];
                f.overlapping_signals = s_axis_tdata[52:49];
                f.radio_powered_down  = s_axis_tdata[53];
                f.next_channel_hint   = s_axis_tdata[58:54];
                want = filter_frame(f);
                expected_verdicts.insert(expected_verdicts.size(), want);
            end

            mismatches       <= fail_count;
            verdicts_pending <= expected_verdicts.size();
        end
    end

endmodule

### dv/rx_frame_address_and_duplicate_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rx_frame_address_and_duplicate_filter_tb
// Drives frames into the rx frame filter: a short directed run over address,
// radio, duplicate and full-table cases, then random frames under several
// settings and idle patterns. Checking is done by rxafdf_verdict_checker.
// ----------------------------------------------------------------------------
module rx_frame_address_and_duplicate_filter_tb;
    import rxafdf_pkg::*;

    localparam int          RANDOM_FRAMES   = 1500;
    localparam int          SEGMENTS        = 6;
    localparam int          STALL_LIMIT     = 4000;
    localparam int          POOL_SIZE       = 16;
    localparam logic [15:0] BROADCAST       = 16'h0000;
    localparam logic [15:0] OWN_ADDRESS_MAX = 16'hFFFF;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX_B = 2'd3;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;
    logic                    s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic                    s_tready;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;

    int          send_idle_pct  = 18;
    int          recv_idle_pct  = 88;
    int          quiet_cycles   = 0;
    int          mismatches;
    int          verdicts_pending;
    logic [15:0] cur_own        = OWN_ADDRESS_RESET;
    logic        cur_compressed = 1'b0;
    // sources known to sit in the table, and a guide to their last sequence
    logic [15:0] pool_src [POOL_SIZE];
    logic [15:0] pool_seq [POOL_SIZE];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rx_frame_address_and_duplicate_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    rxafdf_verdict_checker verdict_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_axis_tvalid    (s_tvalid),
        .s_axis_tready    (s_tready),
        .s_axis_tdata     (s_tdata),
        .m_axis_tvalid    (m_tvalid),
        .m_axis_tready    (m_tready),
        .m_axis_tdata     (m_tdata),
        .mismatches       (mismatches),
        .verdicts_pending (verdicts_pending)
    );

    // receiver backpressure
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // watchdog: cycles with no beat and no register write
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // beat layout: dest, source, sequence, ack, signals, down, hint, pad
    function automatic logic [IN_TDATA_W-1:0] frame_beat(input item_t f);
        return {5'b0, f.next_channel_hint, f.radio_powered_down, f.overlapping_signals,
                f.ack_requested, f.frame_sequence, f.source_address, f.dest_address};
    endfunction

    task automatic send_frame(input item_t f);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= frame_beat(f);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic [15:0] dest, input logic [15:0] src,
                               input logic [15:0] seq, input logic ack,
                               input logic [3:0] sig, input logic down,
                               input logic [4:0] hint);
        item_t f;
        f.dest_address        = dest;
        f.source_address      = src;
        f.frame_sequence      = seq;
        f.ack_requested       = ack;
        f.overlapping_signals = sig;
        f.radio_powered_down  = down;
        f.next_channel_hint   = hint;
        send_frame(f);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and wait until every verdict beat is back
    task automatic settle(input int extra);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (verdicts_pending != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] own, input logic comp);
        logic [14:0] junk;
        junk = 15'($urandom_range(0, 32767));
        settle(4);
        write_reg(CFG_OWN_ADDRESS, own);
        // upper bits of the mode write carry noise
        write_reg(CFG_COMPRESSED_MODE, {junk, comp});
        cur_own        = own;
        cur_compressed = comp;
    endtask

    // mostly known sources with plausible sequence numbers, some strangers
    task automatic random_frame(output item_t f);
        int          p;
        int          pick;
        logic [16:0] nxt;
        p    = $urandom_range(0, POOL_SIZE - 1);
        pick = $urandom_range(0, 99);
        if (pick < 30)
            f.dest_address = BROADCAST;
        else if (pick < 75)
            f.dest_address = cur_own;
        else
            f.dest_address = 16'($urandom_range(0, 65535));

        if ($urandom_range(0, 99) < 85)
        begin
            f.source_address = pool_src[p];
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                nxt = {1'b0, pool_seq[p]} + 17'($urandom_range(1, 40));
                pool_seq[p] = nxt[16] ? 16'hFFFF : nxt[15:0];
                f.frame_sequence = pool_seq[p];
            end
            else if (pick < 70)
                f.frame_sequence = pool_seq[p];
            else
                f.frame_sequence = 16'($urandom_range(0, pool_seq[p]));
        end
        else
        begin
            f.source_address = 16'($urandom_range(0, 65535));
            f.frame_sequence = 16'($urandom_range(0, 65535));
        end

        f.ack_requested = 1'($urandom_range(0, 1));
        if (cur_compressed && $urandom_range(0, 99) < 75)
        begin
            f.overlapping_signals = 4'($urandom_range(0, 1));
            f.radio_powered_down  = 1'b0;
        end
        else
        begin
            f.overlapping_signals = 4'($urandom_range(0, 15));
            f.radio_powered_down  = 1'($urandom_range(0, 1));
        end
        f.next_channel_hint = 5'($urandom_range(0, 31));
    endtask

    initial
    begin
        item_t f;
        int    k;
        int    seg;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // standard mode, lowest own address; spare indexes must do nothing
        apply_settings(OWN_ADDRESS_RESET, 1'b0);
        write_reg(CFG_SPARE_INDEX_A, 16'h0002);
        write_reg(CFG_SPARE_INDEX_B, 16'hFFFF);

        // broadcast, new source; radio flags are ignored in standard mode
        send_fields(BROADCAST, 16'h0000, 16'h0000, 1'b1, 4'd15, 1'b1, 5'd31);
        // equal sequence is a duplicate, still acked
        send_fields(16'h0001, 16'h0000, 16'h0000, 1'b1, 4'd0, 1'b0, 5'd0);
        send_fields(16'h0001, 16'hFFFF, 16'hFFFF, 1'b0, 4'd0, 1'b0, 5'd0);
        // smaller sequence is a duplicate
        send_fields(BROADCAST, 16'hFFFF, 16'h8000, 1'b1, 4'd1, 1'b0, 5'd3);
        send_fields(16'h0001, 16'h0000, 16'h0001, 1'b1, 4'd0, 1'b0, 5'd0);
        // unicast to someone else is dropped, no ack
        send_fields(16'h0002, 16'h0000, 16'h0002, 1'b1, 4'd0, 1'b0, 5'd0);
        send_fields(16'hFFFF, 16'h0000, 16'h0003, 1'b1, 4'd0, 1'b0, 5'd0);

        // compressed mode, highest own address
        apply_settings(OWN_ADDRESS_MAX, 1'b1);
        // hint above 26 passes through
        send_fields(OWN_ADDRESS_MAX, 16'h0003, 16'h0005, 1'b1, 4'd1, 1'b0, 5'd31);
        // busy radio, then powered-down radio
        send_fields(BROADCAST, 16'h0003, 16'h0006, 1'b1, 4'd2, 1'b0, 5'd4);
        send_fields(BROADCAST, 16'h0003, 16'h0007, 1'b1, 4'd0, 1'b1, 5'd4);
        // address check wins over the radio check
        send_fields(16'h0001, 16'h0003, 16'h0008, 1'b1, 4'd15, 1'b1, 5'd4);
        send_fields(BROADCAST, 16'h0003, 16'h0005, 1'b1, 4'd0, 1'b0, 5'd26);

        // fill the rest of the table, then one stranger
        pool_src[0] = 16'h0000;
        pool_seq[0] = 16'h0001;
        pool_src[1] = 16'hFFFF;
        pool_seq[1] = 16'hFFFF;
        pool_src[2] = 16'h0003;
        pool_seq[2] = 16'h0005;
        for (k = 3; k < POOL_SIZE; k++)
        begin
            pool_src[k] = 16'h0100 + 16'(k);
            pool_seq[k] = 16'($urandom_range(0, 16'hC000));
            send_fields(BROADCAST, pool_src[k], pool_seq[k], 1'($urandom_range(0, 1)),
                        4'($urandom_range(0, 1)), 1'b0, 5'($urandom_range(0, 31)));
        end
        send_fields(OWN_ADDRESS_MAX, 16'h4242, 16'h1234, 1'b1, 4'd0, 1'b0, 5'd7);

        // random frames: three idle patterns, two settings each
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0: apply_settings(OWN_ADDRESS_RESET, 1'b0);
                1: apply_settings(16'($urandom_range(1, 65535)), 1'b1);
                2:
                begin
                    settle(4);
                    send_idle_pct <= 88;
                    recv_idle_pct <= 18;
                    apply_settings(OWN_ADDRESS_MAX, 1'b1);
                end
                3: apply_settings(16'($urandom_range(1, 65535)), 1'b0);
                4:
                begin
                    settle(4);
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                    apply_settings(16'($urandom_range(1, 65535)), 1'b1);
                end
                default: apply_settings(16'($urandom_range(1, 65535)), 1'b0);
            endcase
            repeat (RANDOM_FRAMES / SEGMENTS)
            begin
                random_frame(f);
                send_frame(f);
            end
        end

        settle(25);
        if (mismatches == 0 && verdicts_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
